// ===== rtl/gble_pkg.sv =====
// gble_pkg: command codes, field widths and the controller-to-datapath
// command struct for the gap buffer line editor; no dependencies
`default_nettype none

package gble_pkg;

  localparam int CmdW   = 3;
  localparam int CharW  = 8;
  localparam int IdxW   = 6;
  localparam int CountW = 6;

  localparam logic [CmdW-1:0] CMD_INSERT    = 3'd0;
  localparam logic [CmdW-1:0] CMD_LEFT      = 3'd1;
  localparam logic [CmdW-1:0] CMD_RIGHT     = 3'd2;
  localparam logic [CmdW-1:0] CMD_BACKSPACE = 3'd3;
  localparam logic [CmdW-1:0] CMD_DELETE    = 3'd4;
  localparam logic [CmdW-1:0] CMD_TRUNCATE  = 3'd5;
  localparam logic [CmdW-1:0] CMD_READ      = 3'd6;

  // issue: latch the item and start the store read
  // exec:  finish the item, update the gap and load the result register
  typedef struct packed {
    logic issue;
    logic exec;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/gble_ctrl.sv =====
// gble_ctrl: two-state sequencer and result valid for the line editor
// depends on gble_pkg
`default_nettype none

module gble_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output gble_pkg::ctrl_t    ctrl_o
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    ctrl_o.issue = in_valid_i && (state_q == ST_IDLE);
    // result register must be free or being taken in this cycle
    ctrl_o.exec  = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);

    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (ctrl_o.issue) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (ctrl_o.exec) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (ctrl_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/gble_dp.sv =====
// gble_dp: character store, gap pointers, item registers and result register
// depends on gble_pkg; sequenced by gble_ctrl
`default_nettype none

module gble_dp #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gble_pkg::ctrl_t               ctrl_i,
  input  wire logic [gble_pkg::CmdW-1:0]     cmd_i,
  input  wire logic [gble_pkg::CharW-1:0]    char_in_i,
  input  wire logic [gble_pkg::IdxW-1:0]     text_index_i,
  output logic                               ok_o,
  output logic [gble_pkg::CharW-1:0]         char_out_o,
  output logic [gble_pkg::CountW-1:0]        left_count_o,
  output logic [gble_pkg::CountW-1:0]        right_count_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MW = (AW > gble_pkg::IdxW) ? AW : gble_pkg::IdxW;
  localparam int WW = ((MW > gble_pkg::CountW) ? MW : gble_pkg::CountW) + 1;
  localparam logic [AW-1:0] Top = AW'(CAPACITY - 1);

  logic [gble_pkg::CharW-1:0] mem [CAPACITY];

  logic [AW-1:0]              gs_q, gs_d, gl_q, gl_d;
  logic [gble_pkg::CmdW-1:0]  cmd_q;
  logic [gble_pkg::CharW-1:0] char_q;
  logic                       hit_q;
  logic [gble_pkg::CharW-1:0] rdata_q;

  logic [WW-1:0]              idx_w, gs_w, gl_w, right_w, diff_w, sum_w;
  logic                       in_left, read_hit;
  logic [AW-1:0]              raddr;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [gble_pkg::CharW-1:0] wdata;
  logic                       ok_d;
  logic [gble_pkg::CharW-1:0] rd_d;
  logic [WW-1:0]              left_n_w, right_n_w;

  // read address for the accepted item, from the current gap
  always_comb begin
    idx_w    = WW'(text_index_i);
    gs_w     = WW'(gs_q);
    gl_w     = WW'(gl_q);
    right_w  = WW'(Top - gl_q);
    diff_w   = idx_w - gs_w;
    in_left  = idx_w < gs_w;
    read_hit = in_left || (diff_w < right_w);
    sum_w    = gl_w + WW'(1) + diff_w;
    case (cmd_i)
      gble_pkg::CMD_LEFT:  raddr = gs_q - AW'(1);
      gble_pkg::CMD_RIGHT: raddr = gl_q + AW'(1);
      gble_pkg::CMD_READ:  raddr = in_left ? idx_w[AW-1:0] : sum_w[AW-1:0];
      default:             raddr = gs_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      cmd_q   <= cmd_i;
      char_q  <= char_in_i;
      hit_q   <= read_hit;
      rdata_q <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // finish the item
  always_comb begin
    gs_d  = gs_q;
    gl_d  = gl_q;
    we    = 1'b0;
    waddr = gs_q;
    wdata = char_q;
    ok_d  = 1'b0;
    rd_d  = '0;
    case (cmd_q)
      gble_pkg::CMD_INSERT: begin
        if (gs_q != gl_q) begin
          we   = 1'b1;
          gs_d = gs_q + AW'(1);
          ok_d = 1'b1;
        end
      end
      gble_pkg::CMD_LEFT: begin
        if (gs_q != '0) begin
          we    = 1'b1;
          waddr = gl_q;
          wdata = rdata_q;
          gs_d  = gs_q - AW'(1);
          gl_d  = gl_q - AW'(1);
          ok_d  = 1'b1;
        end
      end
      gble_pkg::CMD_RIGHT: begin
        if (gl_q != Top) begin
          we    = 1'b1;
          wdata = rdata_q;
          gs_d  = gs_q + AW'(1);
          gl_d  = gl_q + AW'(1);
          ok_d  = 1'b1;
        end
      end
      gble_pkg::CMD_BACKSPACE: begin
        if (gs_q != '0) begin
          gs_d = gs_q - AW'(1);
          ok_d = 1'b1;
        end
      end
      gble_pkg::CMD_DELETE: begin
        if (gl_q != Top) begin
          gl_d = gl_q + AW'(1);
          ok_d = 1'b1;
        end
      end
      gble_pkg::CMD_TRUNCATE: begin
        gl_d = Top;
        ok_d = 1'b1;
      end
      gble_pkg::CMD_READ: begin
        ok_d = hit_q;
        rd_d = hit_q ? rdata_q : '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    we        = we && ctrl_i.exec;
    left_n_w  = WW'(gs_d);
    right_n_w = WW'(Top - gl_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q <= '0;
      gl_q <= Top;
    end else if (ctrl_i.exec) begin
      gs_q <= gs_d;
      gl_q <= gl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      ok_o          <= ok_d;
      char_out_o    <= rd_d;
      left_count_o  <= left_n_w[gble_pkg::CountW-1:0];
      right_count_o <= right_n_w[gble_pkg::CountW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gap_buffer_line_editor.sv =====
// gap_buffer_line_editor: top level of the one-line gap buffer editor
// depends on gble_pkg, gble_ctrl, gble_dp
//
//   channel  handshake              payload
//   -------  ---------------------  -------------------------------------------
//   in       in_valid_i/in_stall_o  cmd_i, char_in_i, text_index_i
//   out      out_valid_o/out_stall_i ok_o, char_out_o, left_count_o,
//                                   right_count_o
//
// every item is accepted with the synchronous read of the character store, then
// finished by at most one store write, the gap pointer update and the load of
// the result register; the next item can be taken in the cycle after the
// previous one finishes
// reset clears the gap to the whole store and empties the result register;
// the store itself is not cleared
// a stalled result holds; a following item is accepted and waits to finish
// until the result register frees up
`default_nettype none

module gap_buffer_line_editor #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // item in
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [gble_pkg::CmdW-1:0]     cmd_i,
  input  wire logic [gble_pkg::CharW-1:0]    char_in_i,
  input  wire logic [gble_pkg::IdxW-1:0]     text_index_i,
  // item out
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               ok_o,
  output logic [gble_pkg::CharW-1:0]         char_out_o,
  output logic [gble_pkg::CountW-1:0]        left_count_o,
  output logic [gble_pkg::CountW-1:0]        right_count_o
);

  // issue/exec strobes from the sequencer to the datapath
  gble_pkg::ctrl_t ctrl;

  // sequencer: idle -> exec, holds in exec while the result is stalled
  gble_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  // store, gap pointers and result payload
  gble_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cmd_i         (cmd_i),
    .char_in_i     (char_in_i),
    .text_index_i  (text_index_i),
    .ok_o          (ok_o),
    .char_out_o    (char_out_o),
    .left_count_o  (left_count_o),
    .right_count_o (right_count_o)
  );

endmodule

`default_nettype wire
